// File: hdl/psg_tone_noise_generator_assert.svh
// assertion macros for the sound generator
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

// checked outside reset
`define PSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define PSG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

   localparam int CNT_W    = 24;
   localparam int PERIOD_W = 14;
   localparam int RELOAD_W = PERIOD_W + 1;
   localparam int LEVEL_W  = 13;
   localparam int CYCLES_W = 12;
   localparam int NPER_W   = 12;
   localparam int SR_W     = 16;
   localparam int POS_W    = 4;

   localparam logic signed [CNT_W-1:0] COUNTER_MIN = {1'b1, {(CNT_W-1){1'b0}}};

   // register index and rate codes of the write byte
   localparam logic [2:0] IDX_NOISE_CTRL = 3'b110;
   localparam logic [1:0] RATE_TONE2     = 2'b11;

   // tone period at or below this holds the channel high
   localparam logic [PERIOD_W-1:0] SHORT_PERIOD = 14'd16;
   localparam logic [NPER_W-1:0]   NOISE_BASE   = 12'd512;

   // configuration register indexes
   localparam logic [1:0] CSR_TAP_MASK = 2'd0;
   localparam logic [1:0] CSR_FB_POS   = 2'd1;

   localparam logic [SR_W-1:0]  TAP_MASK_RESET = 16'd9;
   localparam logic [POS_W-1:0] FB_POS_RESET   = 4'd15;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             expired;
   } cnt_res_type;

   function automatic logic [LEVEL_W-1:0] atten_value(input logic [3:0] code);
      logic [LEVEL_W-1:0] v;
      case (code)
         4'd0:    v = 13'd8191;
         4'd1:    v = 13'd6506;
         4'd2:    v = 13'd5167;
         4'd3:    v = 13'd4104;
         4'd4:    v = 13'd3259;
         4'd5:    v = 13'd2588;
         4'd6:    v = 13'd2055;
         4'd7:    v = 13'd1632;
         4'd8:    v = 13'd1296;
         4'd9:    v = 13'd1029;
         4'd10:   v = 13'd817;
         4'd11:   v = 13'd648;
         4'd12:   v = 13'd514;
         4'd13:   v = 13'd408;
         4'd14:   v = 13'd324;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/psg_down_counter.sv
`timescale 1ns / 1ps

module psg_down_counter (
   input  logic [psg_pkg::CNT_W-1:0]    count,
   input  logic [psg_pkg::CYCLES_W-1:0] cycles,
   input  logic [psg_pkg::RELOAD_W-1:0] reload,
   output psg_pkg::cnt_res_type         res
);
   import psg_pkg::*;

   logic signed [CNT_W:0]   diff;
   logic signed [CNT_W-1:0] sat;

   always_comb begin
      diff = $signed({count[CNT_W-1], count}) - $signed({{(CNT_W-CYCLES_W+1){1'b0}}, cycles});
      // saturate at the most negative value, no wrap
      if (diff < $signed({COUNTER_MIN[CNT_W-1], COUNTER_MIN})) begin
         sat = COUNTER_MIN;
      end else begin
         sat = diff[CNT_W-1:0];
      end
      res.expired = sat[CNT_W-1] || (sat == '0);
      if (res.expired) begin
         res.count = sat + $signed({{(CNT_W-RELOAD_W){1'b0}}, reload});
      end else begin
         res.count = sat;
      end
   end

endmodule

// File: hdl/psg_tone_noise_generator.sv
// each req_ transfer fills the rsp_ result register in the following cycle
// throughput: one item per cycle while req_stall is low; each item updates the generator state in one pass
// a new item is taken whenever the result register is empty or being read
// reset: synchronous, clears all generator state and the result valid flag
// configuration resets to tap mask 9 and feedback position 15
`timescale 1ns / 1ps

module psg_tone_noise_generator (
   input  logic                          clock,
   input  logic                          reset,
   // item channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [7:0]                    req_write_byte,
   input  logic [psg_pkg::CYCLES_W-1:0]  req_tick_cycles,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [psg_pkg::LEVEL_W-1:0]   rsp_tone0_level,
   output logic [psg_pkg::LEVEL_W-1:0]   rsp_tone1_level,
   output logic [psg_pkg::LEVEL_W-1:0]   rsp_tone2_level,
   output logic [psg_pkg::LEVEL_W-1:0]   rsp_noise_level,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [psg_pkg::SR_W-1:0]      csr_wdata
);
   import psg_pkg::*;

   `include "psg_tone_noise_generator_assert.svh"

   // configuration registers
   logic [SR_W-1:0]  tap_mask_ff;
   logic [POS_W-1:0] fb_pos_ff;

   // generator state
   logic [2:0]          latched_index_ff, latched_index_in;
   logic [PERIOD_W-1:0] tone_period_ff [3];
   logic [PERIOD_W-1:0] tone_period_in [3];
   logic [NPER_W-1:0]   noise_period_ff, noise_period_in;
   logic                follows_ff, follows_in;
   logic                white_ff, white_in;
   logic [SR_W-1:0]     shift_reg_ff, shift_reg_in;
   logic [CNT_W-1:0]    counter_ff [4];
   logic [CNT_W-1:0]    counter_in [4];
   logic                chan_bit_ff [4];
   logic                chan_bit_in [4];
   logic [LEVEL_W-1:0]  atten_ff [4];
   logic [LEVEL_W-1:0]  atten_in [4];

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  level_ff [4];

   logic                accept;
   logic                tick;
   logic                latch_byte;
   logic [2:0]          wr_index;
   logic                noise_wr;
   logic                feedback;
   logic [RELOAD_W-1:0] noise_reload;
   cnt_res_type         cnt_res [4];

   // hold off new items only while a result waits and the far side stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && req_command;
   assign csr_ready = 1'b1;

   // index after this byte: a latch byte replaces it first
   assign latch_byte = req_write_byte[7];
   assign wr_index   = latch_byte ? req_write_byte[6:4] : latched_index_ff;
   assign noise_wr   = accept && !req_command && (wr_index == IDX_NOISE_CTRL);

   // noise rate either one of the fixed periods or twice tone 2
   assign noise_reload = follows_ff ? {tone_period_ff[2], 1'b0}
                                    : {{(RELOAD_W-NPER_W){1'b0}}, noise_period_ff};

   // white noise feeds back the parity of the tapped bits
   assign feedback = white_ff ? ^(shift_reg_ff & tap_mask_ff) : shift_reg_ff[0];

   // one counter per tone channel
   for (genvar g = 0; g < 3; g++) begin : g_tone
      psg_down_counter u_cnt (
         .count  (counter_ff[g]),
         .cycles (req_tick_cycles),
         .reload ({1'b0, tone_period_ff[g]}),
         .res    (cnt_res[g])
      );
   end

   psg_down_counter u_noise_cnt (
      .count  (counter_ff[3]),
      .cycles (req_tick_cycles),
      .reload (noise_reload),
      .res    (cnt_res[3])
   );

   always_comb begin
      latched_index_in = latched_index_ff;
      noise_period_in  = noise_period_ff;
      follows_in       = follows_ff;
      white_in         = white_ff;
      shift_reg_in     = shift_reg_ff;
      for (int k = 0; k < 3; k++) begin
         tone_period_in[k] = tone_period_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         counter_in[k]  = counter_ff[k];
         chan_bit_in[k] = chan_bit_ff[k];
         atten_in[k]    = atten_ff[k];
      end

      if (tick) begin
         // tone channels: a short period holds the output high
         for (int k = 0; k < 3; k++) begin
            if (tone_period_ff[k] <= SHORT_PERIOD) begin
               chan_bit_in[k] = 1'b1;
            end else begin
               counter_in[k]  = cnt_res[k].count;
               chan_bit_in[k] = chan_bit_ff[k] ^ cnt_res[k].expired;
            end
         end
         // noise channel shifts on each expiry
         counter_in[3] = cnt_res[3].count;
         if (cnt_res[3].expired) begin
            shift_reg_in   = (shift_reg_ff >> 1) | (SR_W'(feedback) << fb_pos_ff);
            chan_bit_in[3] = shift_reg_in[0];
         end
      end else if (accept) begin
         latched_index_in = wr_index;
         // even index below six: tone period, low nibble or high six bits
         for (int k = 0; k < 3; k++) begin
            if (!wr_index[0] && (wr_index[2:1] == 2'(k))) begin
               if (latch_byte) begin
                  tone_period_in[k] = {tone_period_ff[k][13:8], req_write_byte[3:0], 4'b0000};
               end else begin
                  tone_period_in[k] = {req_write_byte[5:0], tone_period_ff[k][7:4], 4'b0000};
               end
            end
         end
         // odd index: attenuation of the channel
         if (wr_index[0]) begin
            atten_in[wr_index[2:1]] = atten_value(req_write_byte[3:0]);
         end
         // noise control: rate, mode and shift register reload
         if (noise_wr) begin
            if (req_write_byte[1:0] != RATE_TONE2) begin
               noise_period_in = NOISE_BASE << req_write_byte[1:0];
               follows_in      = 1'b0;
            end else begin
               follows_in = 1'b1;
            end
            white_in     = req_write_byte[2];
            shift_reg_in = SR_W'(1) << fb_pos_ff;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_mask_ff      <= TAP_MASK_RESET;
         fb_pos_ff        <= FB_POS_RESET;
         latched_index_ff <= '0;
         noise_period_ff  <= '0;
         follows_ff       <= 1'b0;
         white_ff         <= 1'b0;
         shift_reg_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            tone_period_ff[k] <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            counter_ff[k]  <= '0;
            chan_bit_ff[k] <= 1'b0;
            atten_ff[k]    <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAP_MASK: tap_mask_ff <= csr_wdata;
               CSR_FB_POS:   fb_pos_ff   <= csr_wdata[POS_W-1:0];
               default:      ;
            endcase
         end
         latched_index_ff <= latched_index_in;
         noise_period_ff  <= noise_period_in;
         follows_ff       <= follows_in;
         white_ff         <= white_in;
         shift_reg_ff     <= shift_reg_in;
         rsp_valid_ff     <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            tone_period_ff[k] <= tone_period_in[k];
         end
         for (int k = 0; k < 4; k++) begin
            counter_ff[k]  <= counter_in[k];
            chan_bit_ff[k] <= chan_bit_in[k];
            atten_ff[k]    <= atten_in[k];
         end
      end
   end

   // result levels taken from the state after this item
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 4; k++) begin
            level_ff[k] <= chan_bit_in[k] ? atten_in[k] : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tone0_level = level_ff[0];
   assign rsp_tone1_level = level_ff[1];
   assign rsp_tone2_level = level_ff[2];
   assign rsp_noise_level = level_ff[3];

   // checks
   `PSG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
   `PSG_ASSERT(a_accept_result, accept |=> rsp_valid, "transfer without result")
   `PSG_ASSERT(a_no_overrun, (rsp_valid && rsp_stall) |-> req_stall, "item taken over a waiting result")
   `PSG_ASSERT(a_short_tone, (tick && (tone_period_ff[0] <= SHORT_PERIOD)) |=> chan_bit_ff[0], "short tone period not held high")
   `PSG_ASSERT(a_noise_reload, noise_wr |=> $onehot(shift_reg_ff), "noise control did not reload shift register")

endmodule
